// ===== hdl/y2a_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package y2a_pkg;

  // Fixed-point format of the chroma weights
  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned WGT_W  = COEF_FRAC_BITS + 1;   // largest weight is below 2.0
  localparam int unsigned PROD_W = COEF_FRAC_BITS + 10;  // 8b signed chroma x (WGT_W+1)b signed
  localparam int unsigned TERM_W = 10;                   // truncated chroma term, |term| < 256
  localparam int unsigned CHAN_W = 11;                   // luma plus term before clamping

  // Weights, round half up of w * 2^COEF_FRAC_BITS
  localparam longint unsigned FIX_ONE = 64'(1) << COEF_FRAC_BITS;
  localparam logic [WGT_W-1:0] W_R_C2 = WGT_W'((64'(1772) * FIX_ONE + 64'(500)) / 64'(1000));
  localparam logic [WGT_W-1:0] W_G_C2 = WGT_W'((64'(344) * FIX_ONE + 64'(500)) / 64'(1000));
  localparam logic [WGT_W-1:0] W_G_C1 = WGT_W'((64'(714) * FIX_ONE + 64'(500)) / 64'(1000));
  localparam logic [WGT_W-1:0] W_B_C1 = WGT_W'((64'(1402) * FIX_ONE + 64'(500)) / 64'(1000));

  // Bias added to negative products so the arithmetic shift truncates toward zero
  localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'(FIX_ONE - 64'(1));

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] CHAN_MAX     = 8'hFF;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One word between front and back: the four lumas and the shared chroma terms
  typedef struct packed {
    logic [7:0]               luma_tl;
    logic [7:0]               luma_tr;
    logic [7:0]               luma_bl;
    logic [7:0]               luma_br;
    logic signed [TERM_W-1:0] dr;
    logic signed [TERM_W-1:0] dg;
    logic signed [TERM_W-1:0] db;
  } term_t;

  // Chroma minus 128 as a signed byte is the sample with its top bit flipped
  function automatic logic signed [7:0] chroma_centered(input logic [7:0] c);
    return signed'({~c[7], c[6:0]});
  endfunction

  // Exact product of a centered chroma sample and an unsigned weight
  function automatic logic signed [PROD_W-1:0] mul_wgt(input logic signed [7:0] c,
                                                      input logic [WGT_W-1:0] w);
    logic signed [PROD_W-1:0] ce;
    logic signed [PROD_W-1:0] we;
    ce = PROD_W'(c);
    we = signed'(PROD_W'(w));
    return ce * we;
  endfunction

  // Drop the fraction, rounding toward zero
  function automatic logic signed [TERM_W-1:0] trunc_term(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    logic signed [PROD_W-1:0] s;
    b = p[PROD_W-1] ? signed'(TRUNC_BIAS) : '0;
    s = (p + b) >>> COEF_FRAC_BITS;
    return s[TERM_W-1:0];
  endfunction

  // Saturate a channel to 0..255
  function automatic logic [7:0] clamp_u8(input logic signed [CHAN_W-1:0] x);
    logic [7:0] r;
    if (x[CHAN_W-1]) begin
      r = '0;
    end else if (x[CHAN_W-2:8] != '0) begin
      r = CHAN_MAX;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // One opaque ARGB pixel
  function automatic logic [31:0] make_pixel(input logic [7:0] y,
                                             input logic signed [TERM_W-1:0] dr,
                                             input logic signed [TERM_W-1:0] dg,
                                             input logic signed [TERM_W-1:0] db);
    logic signed [CHAN_W-1:0] ye;
    logic signed [CHAN_W-1:0] r;
    logic signed [CHAN_W-1:0] g;
    logic signed [CHAN_W-1:0] b;
    ye = signed'(CHAN_W'(y));
    r  = ye + CHAN_W'(dr);
    g  = ye - CHAN_W'(dg);
    b  = ye + CHAN_W'(db);
    return {ALPHA_OPAQUE, clamp_u8(r), clamp_u8(g), clamp_u8(b)};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/y2a_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one 2x2 luma block with its chroma pair per word
interface y2a_blk_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [7:0] chroma_first;
  logic [7:0] chroma_second;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    output chroma_first, chroma_second,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    input  chroma_first, chroma_second,
    output ready
  );
endinterface

// Output channel: four ARGB8888 pixels per word
interface y2a_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_top_left;
  logic [31:0] pixel_top_right;
  logic [31:0] pixel_bottom_left;
  logic [31:0] pixel_bottom_right;

  modport source (
    output valid, pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/yuv420_block_to_argb.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 4:2:0 block to ARGB8888 converter.
// Input channel blk_i: one word is a 2x2 luma block plus the chroma pair it
// shares (first and second plane, each offset by 128). Output channel pix_o:
// one word is the four opaque pixels of that block, alpha in bits 31:24, then
// red, green, blue.
// Both channels use valid/ready; a word moves on a clock edge with both high.
// Throughput: one word per clock, sustained while pix_o.ready is high, set by the
// fully pipelined path (product stage, truncation stage, two-entry queue, output register).
// When the receiver holds ready low the output word stays put; the front
// keeps taking words until the queue and both front stages are full, then
// drops blk_i.ready. No word is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and the queue; no
// configuration exists and the block is ready right after reset.
module yuv420_block_to_argb (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  y2a_blk_if.sink   blk_i,
  y2a_pix_if.source pix_o
);
  import y2a_pkg::*;

  term_t front_term;
  logic  front_valid;
  logic  front_ready;
  term_t back_term;
  logic  back_valid;
  logic  back_ready;

  y2a_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blk_i        (blk_i),
    .term_o       (front_term),
    .term_valid_o (front_valid),
    .term_ready_i (front_ready)
  );

  y2a_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (front_term),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_data_o  (back_term),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  y2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_i       (back_term),
    .term_valid_i (back_valid),
    .term_ready_o (back_ready),
    .pix_o        (pix_o)
  );

endmodule

`default_nettype wire

// ===== hdl/y2a_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module y2a_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  y2a_blk_if.sink            blk_i,
  output y2a_pkg::term_t     term_o,
  output logic               term_valid_o,
  input  wire logic          term_ready_i
);
  import y2a_pkg::*;

  // Stage 1: products
  logic                     s1_valid_q;
  logic                     s1_ready;
  logic [7:0]               s1_luma_q [4];
  logic signed [PROD_W-1:0] prod_r_q;
  logic signed [PROD_W-1:0] prod_gc2_q;
  logic signed [PROD_W-1:0] prod_gc1_q;
  logic signed [PROD_W-1:0] prod_b_q;
  logic signed [7:0]        c1;
  logic signed [7:0]        c2;

  // Stage 2: truncated terms
  logic                     s2_valid_q;
  logic                     s2_ready;
  term_t                    term_q;
  logic signed [PROD_W-1:0] gsum;

  assign s2_ready    = !s2_valid_q || term_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign blk_i.ready = s1_ready;

  assign c1 = chroma_centered(blk_i.chroma_first);
  assign c2 = chroma_centered(blk_i.chroma_second);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= blk_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && blk_i.valid) begin
      s1_luma_q[0] <= blk_i.luma_top_left;
      s1_luma_q[1] <= blk_i.luma_top_right;
      s1_luma_q[2] <= blk_i.luma_bottom_left;
      s1_luma_q[3] <= blk_i.luma_bottom_right;
      prod_r_q     <= mul_wgt(c2, W_R_C2);
      prod_gc2_q   <= mul_wgt(c2, W_G_C2);
      prod_gc1_q   <= mul_wgt(c1, W_G_C1);
      prod_b_q     <= mul_wgt(c1, W_B_C1);
    end
  end

  // Green terms are summed exactly, then truncated once
  assign gsum = prod_gc2_q + prod_gc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      term_q.luma_tl <= s1_luma_q[0];
      term_q.luma_tr <= s1_luma_q[1];
      term_q.luma_bl <= s1_luma_q[2];
      term_q.luma_br <= s1_luma_q[3];
      term_q.dr      <= trunc_term(prod_r_q);
      term_q.dg      <= trunc_term(gsum);
      term_q.db      <= trunc_term(prod_b_q);
    end
  end

  assign term_o       = term_q;
  assign term_valid_o = s2_valid_q;

endmodule

`default_nettype wire

// ===== hdl/y2a_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module y2a_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire y2a_pkg::term_t wr_data_i,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  output y2a_pkg::term_t     rd_data_o,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i
);
  import y2a_pkg::*;

  term_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  push;
  logic                  pop;

  assign wr_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("fifo count missed a push");

  a_cnt_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("fifo count missed a pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("fifo pointers disagree with count");

endmodule

`default_nettype wire

// ===== hdl/y2a_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module y2a_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire y2a_pkg::term_t term_i,
  input  wire logic           term_valid_i,
  output logic                term_ready_o,
  y2a_pix_if.source           pix_o
);
  import y2a_pkg::*;

  logic        out_valid_q;
  logic        load;
  logic [31:0] pix_q [4];

  assign term_ready_o = !out_valid_q || pix_o.ready;
  assign load         = term_valid_i && term_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (term_ready_o) begin
      out_valid_q <= term_valid_i;
    end
  end

  // Add luma, clamp, pack
  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q[0] <= make_pixel(term_i.luma_tl, term_i.dr, term_i.dg, term_i.db);
      pix_q[1] <= make_pixel(term_i.luma_tr, term_i.dr, term_i.dg, term_i.db);
      pix_q[2] <= make_pixel(term_i.luma_bl, term_i.dr, term_i.dg, term_i.db);
      pix_q[3] <= make_pixel(term_i.luma_br, term_i.dr, term_i.dg, term_i.db);
    end
  end

  assign pix_o.valid              = out_valid_q;
  assign pix_o.pixel_top_left     = pix_q[0];
  assign pix_o.pixel_top_right    = pix_q[1];
  assign pix_o.pixel_bottom_left  = pix_q[2];
  assign pix_o.pixel_bottom_right = pix_q[3];

endmodule

`default_nettype wire

// ===== verif/y2a_pixel_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the four ARGB pixels of every block taken
// in and compares them in order with the words that come out.
module y2a_pixel_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  y2a_blk_if        blk_mon_i,
  y2a_pix_if        pix_mon_i,
  output int        mismatch_cnt_o,
  output int        pending_cnt_o
);

  typedef struct packed {
    logic [31:0] top_left;
    logic [31:0] top_right;
    logic [31:0] bottom_left;
    logic [31:0] bottom_right;
  } argb_quad_t;

  localparam longint Q_ONE = longint'(1) << y2a_pkg::COEF_FRAC_BITS;

  argb_quad_t pending_quads[$];
  int         n_err = 0;
  int         n_pending = 0;

  assign mismatch_cnt_o = n_err;
  assign pending_cnt_o  = n_pending;

  // Weight in thousandths to fixed point, rounded half up
  function automatic longint q_weight(input longint milli);
    return (milli * Q_ONE + 500) / 1000;
  endfunction

  function automatic logic [7:0] sat_byte(input longint v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  function automatic logic [31:0] argb_pixel(input logic [7:0] luma, input longint dr,
                                             input longint dg, input longint db);
    longint y;
    y = longint'(luma);
    return {8'hFF, sat_byte(y + dr), sat_byte(y - dg), sat_byte(y + db)};
  endfunction

  // Chroma terms are shared by the block; SV integer division truncates toward zero
  function automatic argb_quad_t predict_quad(input logic [7:0] y_tl, input logic [7:0] y_tr,
                                              input logic [7:0] y_bl, input logic [7:0] y_br,
                                              input logic [7:0] cf, input logic [7:0] cs);
    longint     c1;
    longint     c2;
    longint     dr;
    longint     dg;
    longint     db;
    argb_quad_t q;
    c1 = longint'(cf) - 128;
    c2 = longint'(cs) - 128;
    dr = (q_weight(1772) * c2) / Q_ONE;
    dg = (q_weight(344) * c2 + q_weight(714) * c1) / Q_ONE;
    db = (q_weight(1402) * c1) / Q_ONE;
    q.top_left     = argb_pixel(y_tl, dr, dg, db);
    q.top_right    = argb_pixel(y_tr, dr, dg, db);
    q.bottom_left  = argb_pixel(y_bl, dr, dg, db);
    q.bottom_right = argb_pixel(y_br, dr, dg, db);
    return q;
  endfunction

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  task automatic check_pixel(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want)
      flag_error($sformatf("%s pixel: expected %08h, got %08h", name, want, got));
  endtask

  // Push the prediction for a taken block, then check any word leaving
  always @(posedge clk_i) begin : watch
    argb_quad_t want;
    if (rst_ni) begin
      if (blk_mon_i.valid && blk_mon_i.ready)
        pending_quads.push_back(predict_quad(blk_mon_i.luma_top_left,
                                             blk_mon_i.luma_top_right,
                                             blk_mon_i.luma_bottom_left,
                                             blk_mon_i.luma_bottom_right,
                                             blk_mon_i.chroma_first,
                                             blk_mon_i.chroma_second));
      if (pix_mon_i.valid && pix_mon_i.ready) begin
        if (pending_quads.size() == 0) begin
          flag_error($sformatf("output word with nothing expected: %08h %08h %08h %08h",
                               pix_mon_i.pixel_top_left, pix_mon_i.pixel_top_right,
                               pix_mon_i.pixel_bottom_left, pix_mon_i.pixel_bottom_right));
        end else begin
          want = pending_quads.pop_front();
          check_pixel("top left", want.top_left, pix_mon_i.pixel_top_left);
          check_pixel("top right", want.top_right, pix_mon_i.pixel_top_right);
          check_pixel("bottom left", want.bottom_left, pix_mon_i.pixel_bottom_left);
          check_pixel("bottom right", want.bottom_right, pix_mon_i.pixel_bottom_right);
        end
      end
      n_pending = pending_quads.size();
    end
  end

endmodule

// ===== verif/tb_yuv420_block_to_argb.sv =====
`timescale 1ns / 1ps

module tb_yuv420_block_to_argb;

  typedef struct packed {
    logic [7:0] y_tl;
    logic [7:0] y_tr;
    logic [7:0] y_bl;
    logic [7:0] y_br;
    logic [7:0] cf;
    logic [7:0] cs;
  } yuv_block_t;

  localparam int N_RANDOM   = 850;
  localparam int HOLD_START = 150;
  localparam int HOLD_LEN   = 80;

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;
  int         mismatch_cnt;
  int         pending_cnt;
  yuv_block_t blocks[$];

  y2a_blk_if blk ();
  y2a_pix_if pix ();

  yuv420_block_to_argb dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .blk_i  (blk),
    .pix_o  (pix)
  );

  y2a_pixel_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .blk_mon_i      (blk),
    .pix_mon_i      (pix),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_yuv420_block_to_argb: FAIL");
    $finish;
  end

  task automatic add_block(input logic [7:0] y_tl, input logic [7:0] y_tr,
                           input logic [7:0] y_bl, input logic [7:0] y_br,
                           input logic [7:0] cf, input logic [7:0] cs);
    blocks.push_back('{y_tl, y_tr, y_bl, y_br, cf, cs});
  endtask

  // Byte near either end of the range
  function automatic logic [7:0] edge_byte();
    return $urandom_range(1) ? 8'($urandom_range(8)) : 8'($urandom_range(255, 247));
  endfunction

  // Receiver: random stalls, one long hold-off, and a calm stretch
  initial begin : sink_side
    int cyc;
    int hold;
    cyc  = 0;
    hold = 0;
    pix.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_START) hold = HOLD_LEN;
      if (hold > 0) begin
        hold--;
        pix.ready <= 1'b0;
      end else if (cyc >= 350 && cyc < 650) begin
        pix.ready <= 1'b1;
      end else begin
        pix.ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // Stimulus, sender and verdict
  initial begin : source_side
    int idx;
    int sel;
    blk.valid             = 1'b0;
    blk.luma_top_left     = '0;
    blk.luma_top_right    = '0;
    blk.luma_bottom_left  = '0;
    blk.luma_bottom_right = '0;
    blk.chroma_first      = '0;
    blk.chroma_second     = '0;

    // Directed: neutral chroma, chroma extremes, clamping both ways
    add_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128);
    add_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128);
    add_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
    add_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
    add_block(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    add_block(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0);
    add_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd255, 8'd255);
    add_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd0, 8'd0);
    add_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd127, 8'd129);
    add_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd129, 8'd127);
    add_block(8'd128, 8'd127, 8'd1, 8'd254, 8'd1, 8'd254);
    add_block(8'd128, 8'd127, 8'd1, 8'd254, 8'd254, 8'd1);
    add_block(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd128);
    add_block(8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0);
    add_block(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128);
    add_block(8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255);
    add_block(8'd16, 8'd235, 8'd16, 8'd235, 8'd240, 8'd16);
    add_block(8'd16, 8'd235, 8'd16, 8'd235, 8'd16, 8'd240);

    // Random: mostly full range, some weighted toward saturation and neutral chroma
    repeat (N_RANDOM) begin
      sel = $urandom_range(9);
      if (sel <= 5)
        add_block(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
      else if (sel <= 7)
        add_block(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  edge_byte(), edge_byte());
      else if (sel == 8)
        add_block(edge_byte(), edge_byte(), edge_byte(), edge_byte(),
                  8'($urandom), 8'($urandom));
      else
        add_block(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom_range(134, 122)), 8'($urandom_range(134, 122)));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hold a word until taken; idle only between words
    idx = 0;
    while (idx < blocks.size()) begin
      @(posedge clk);
      if (blk.valid && blk.ready) idx++;
      if (blk.valid && !blk.ready) begin
      end else if (idx < blocks.size() &&
                   ((idx >= 300 && idx < 500) || $urandom_range(99) >= 9)) begin
        blk.valid             <= 1'b1;
        blk.luma_top_left     <= blocks[idx].y_tl;
        blk.luma_top_right    <= blocks[idx].y_tr;
        blk.luma_bottom_left  <= blocks[idx].y_bl;
        blk.luma_bottom_right <= blocks[idx].y_br;
        blk.chroma_first      <= blocks[idx].cf;
        blk.chroma_second     <= blocks[idx].cs;
      end else begin
        blk.valid <= 1'b0;
      end
    end

    // Drain, then keep watching the output to catch stray words
    do @(negedge clk); while (pending_cnt != 0);
    repeat (10) @(posedge clk);
    @(negedge clk);

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("tb_yuv420_block_to_argb: PASS");
    end else begin
      $display("tb_yuv420_block_to_argb: FAIL");
    end
    $finish;
  end

endmodule
